### rtl/gnm_pkg.sv
// ----------------------------------------------------------------------------
// gnm_pkg
// Shared types and constants for the gradient normal block.
// ----------------------------------------------------------------------------
package gnm_pkg;

    localparam int PIX_W  = 16;
    localparam int DIFF_W = PIX_W + 1;
    localparam int NRM_W  = 16;
    localparam int COL_W  = 12;
    localparam int MAG_BITS = 15;

    localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] REG_NEGATE_X   = 2'd1;
    localparam logic [1:0] REG_NEGATE_Y   = 2'd2;

    // request to the normalising unit: negated gradient (centre minus neighbour)
    typedef struct packed {
        logic signed [DIFF_W-1:0] vx;
        logic signed [DIFF_W-1:0] vy;
    } gnm_req_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
    } gnm_res_t;

endpackage

### rtl/image_gradient_normal_2d.sv
// ----------------------------------------------------------------------------
// image_gradient_normal_2d
// Forward-difference gradient normal map over a streamed intensity image.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one pixel per request in raster order; tuser carries frame_start.
//   cfg_* writes line_width (0), negate_x (1), negate_y (2); always ready.
//   m_* gives results: while row r+1 streams in, the pixel at column c yields
//   the result for column c-1 of row r; the last pixel of a row also yields
//   the result for the last column, flagged by tlast. First row gives none.
// Sequence:
//   A pixel with no result goes through a line store read, then write-back.
//   Each result then passes through the shared normalising unit: squares and
//   sum, then a square, a product and a compare per magnitude bit, 15 bits for
//   each of two components; a zero gradient skips the bit loop.
//   The next pixel is taken only once every result of this one has been handed
//   to the output register.
// Reset clears counters, control state and output valid and sets line_width to
//   1920; line store contents are undefined until written by the first row of a frame.
// A stalled m_tready holds the output register; the next pixel is still
//   taken and worked on, and the block waits only to hand over a new result.
// ----------------------------------------------------------------------------
module image_gradient_normal_2d #(
    parameter int MAX_LINE = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_value
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] normal_x, [31:16] normal_y, [43:32] pixel_column
    output logic        m_tlast,   // row_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int CW = $clog2(MAX_LINE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_JOB  = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic [12:0] line_width_reg;
    logic        negate_x_reg, negate_y_reg;
    logic [CW-1:0] column_count_reg;
    logic        have_prev_reg;
    logic [15:0] held_below_reg, held_centre_reg;
    logic [15:0] pix_reg;
    logic [CW-1:0] col_reg;
    logic        emit1_reg, emit2_reg, job_sel_reg;
    gnm_pkg::gnm_req_t job0_reg, job1_reg;

    logic        out_valid_reg;
    logic [15:0] out_x_reg, out_y_reg;
    logic [gnm_pkg::COL_W-1:0] out_col_reg;
    logic        out_last_reg;

    logic        s_acc;
    logic [31:0] lw_ext;
    logic [CW-1:0] last_col;
    logic [CW-1:0] col_now;
    logic [15:0] above;
    logic        norm_start, norm_done;
    gnm_pkg::gnm_res_t norm_res;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        lw_ext = 32'(line_width_reg);
        if (lw_ext < 32'd2)
        begin
            last_col = CW'(1);
        end
        else if (lw_ext > 32'(MAX_LINE))
        begin
            last_col = CW'(MAX_LINE - 1);
        end
        else
        begin
            last_col = CW'(lw_ext - 32'd1);
        end
        if (s_tuser)
        begin
            col_now = '0;
        end
        else if (column_count_reg > last_col)
        begin
            col_now = last_col;
        end
        else
        begin
            col_now = column_count_reg;
        end
    end

    gnm_line_mem #(
        .DEPTH (MAX_LINE),
        .AW    (CW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (s_acc),
        .rd_addr (col_now),
        .rd_data (above),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (col_reg),
        .wr_data (pix_reg)
    );

    assign norm_start = (state_reg == ST_JOB);

    gnm_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .req   (job_sel_reg ? job1_reg : job0_reg),
        .done  (norm_done),
        .res   (norm_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            line_width_reg   <= 13'd1920;
            negate_x_reg     <= 1'b0;
            negate_y_reg     <= 1'b0;
            column_count_reg <= '0;
            have_prev_reg    <= 1'b0;
            held_below_reg   <= '0;
            held_centre_reg  <= '0;
            out_valid_reg    <= 1'b0;
            emit1_reg        <= 1'b0;
            emit2_reg        <= 1'b0;
            job_sel_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gnm_pkg::REG_LINE_WIDTH: line_width_reg <= cfg_data;
                    gnm_pkg::REG_NEGATE_X:   negate_x_reg   <= cfg_data[0];
                    gnm_pkg::REG_NEGATE_Y:   negate_y_reg   <= cfg_data[0];
                    default: ;
                endcase
            end

            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        emit1_reg <= have_prev_reg && !s_tuser && (col_now != '0);
                        emit2_reg <= have_prev_reg && !s_tuser && (col_now == last_col);
                        if (col_now == last_col)
                        begin
                            column_count_reg <= '0;
                            have_prev_reg    <= 1'b1;
                        end
                        else
                        begin
                            column_count_reg <= col_now + CW'(1);
                            if (s_tuser)
                            begin
                                have_prev_reg <= 1'b0;
                            end
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    job0_reg.vx <= $signed({1'b0, held_centre_reg}) - $signed({1'b0, above});
                    job0_reg.vy <= $signed({1'b0, held_centre_reg})
                                   - $signed({1'b0, held_below_reg});
                    job1_reg.vx <= '0;
                    job1_reg.vy <= $signed({1'b0, above}) - $signed({1'b0, pix_reg});
                    held_centre_reg <= above;
                    held_below_reg  <= pix_reg;
                    job_sel_reg     <= !emit1_reg;
                    state_reg       <= (emit1_reg || emit2_reg) ? ST_JOB : ST_IDLE;
                end
                ST_JOB:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (norm_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!job_sel_reg && emit2_reg)
                        begin
                            job_sel_reg <= 1'b1;
                            state_reg   <= ST_JOB;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            pix_reg <= s_tdata;
            col_reg <= col_now;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_x_reg    <= negate_x_reg ? -norm_res.nx : norm_res.nx;
            out_y_reg    <= negate_y_reg ? -norm_res.ny : norm_res.ny;
            out_col_reg  <= job_sel_reg ? 12'(col_reg) : 12'(col_reg - CW'(1));
            out_last_reg <= job_sel_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_col_reg, out_y_reg, out_x_reg};
    assign m_tlast  = out_last_reg;

endmodule

### rtl/gnm_line_mem.sv
// ----------------------------------------------------------------------------
// gnm_line_mem
// Line store with one read port and one write port, registered read.
// ----------------------------------------------------------------------------
module gnm_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [gnm_pkg::PIX_W-1:0]    rd_data,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [gnm_pkg::PIX_W-1:0]    wr_data
);

    logic [gnm_pkg::PIX_W-1:0] mem [DEPTH];
    logic [gnm_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/gnm_norm.sv
// ----------------------------------------------------------------------------
// gnm_norm
// Scales (vx, vy) to unit length in Q1.14, rounded to nearest, one
// magnitude bit at a time (square, product, compare), x then y.
// ----------------------------------------------------------------------------
module gnm_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gnm_pkg::gnm_req_t req,
    output logic              done,
    output gnm_pkg::gnm_res_t res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_K    = 3'd3;
    localparam logic [2:0] ST_P    = 3'd4;
    localparam logic [2:0] ST_C    = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [15:0] a_reg, b_reg;
    logic        sx_reg, sy_reg;
    logic [31:0] aa_reg, bb_reg;
    logic [32:0] s_reg;
    logic [31:0] kk_reg;
    logic [48:0] plo_reg;
    logic [47:0] phi_reg;
    logic [14:0] m_reg;
    logic [3:0]  bit_reg;
    logic        comp_reg;
    logic        done_reg;
    gnm_pkg::gnm_res_t res_reg;

    logic [14:0] trial;
    logic [15:0] k;
    logic [65:0] prod;
    logic [65:0] rhs;
    logic [14:0] m_new;
    logic [15:0] mag_s;

    assign trial = m_reg | (15'd1 << bit_reg);
    assign k     = {trial, 1'b0} - 16'd1;
    assign prod  = 66'(plo_reg) + (66'(phi_reg) << 17);
    assign rhs   = comp_reg ? (66'(bb_reg) << 30) : (66'(aa_reg) << 30);
    assign m_new = (prod <= rhs) ? trial : m_reg;
    assign mag_s = {1'b0, m_new};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_SQ;
            ST_SQ:   state_next = ST_SUM;
            ST_SUM:  state_next = (aa_reg == '0 && bb_reg == '0) ? ST_IDLE : ST_K;
            ST_K:    state_next = ST_P;
            ST_P:    state_next = ST_C;
            ST_C:    state_next = (bit_reg == '0 && comp_reg) ? ST_IDLE : ST_K;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_SUM && aa_reg == '0 && bb_reg == '0) ||
                         (state_reg == ST_C && bit_reg == '0 && comp_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sx_reg <= req.vx[gnm_pkg::DIFF_W-1];
                    sy_reg <= req.vy[gnm_pkg::DIFF_W-1];
                    a_reg  <= req.vx[gnm_pkg::DIFF_W-1] ? 16'(-req.vx) : 16'(req.vx);
                    b_reg  <= req.vy[gnm_pkg::DIFF_W-1] ? 16'(-req.vy) : 16'(req.vy);
                end
            end
            ST_SQ:
            begin
                aa_reg <= a_reg * a_reg;
                bb_reg <= b_reg * b_reg;
            end
            ST_SUM:
            begin
                s_reg    <= 33'(aa_reg) + 33'(bb_reg);
                m_reg    <= '0;
                bit_reg  <= 4'(gnm_pkg::MAG_BITS - 1);
                comp_reg <= 1'b0;
                res_reg  <= '0;
            end
            ST_K:
            begin
                kk_reg <= k * k;
            end
            ST_P:
            begin
                plo_reg <= kk_reg * s_reg[16:0];
                phi_reg <= kk_reg * s_reg[32:17];
            end
            ST_C:
            begin
                if (bit_reg == '0)
                begin
                    // component finished: apply the sign of the difference
                    if (!comp_reg)
                    begin
                        res_reg.nx <= sx_reg ? -mag_s : mag_s;
                    end
                    else
                    begin
                        res_reg.ny <= sy_reg ? -mag_s : mag_s;
                    end
                    m_reg    <= '0;
                    bit_reg  <= 4'(gnm_pkg::MAG_BITS - 1);
                    comp_reg <= 1'b1;
                end
                else
                begin
                    m_reg   <= m_new;
                    bit_reg <= bit_reg - 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
